// File: rtl/mbrtu_pkg.sv
// shared types, constants and the crc-16 byte step for the modbus rtu framer
// no dependencies; imported by every module of the block

package mbrtu_pkg;

    // input action codes carried on s_axis_tuser
    localparam logic [1:0] ACT_WRITE = 2'd0;
    localparam logic [1:0] ACT_READ  = 2'd1;
    localparam logic [1:0] ACT_REPLY = 2'd2;

    localparam logic [15:0] CRC_INIT   = 16'hFFFF;
    localparam logic [15:0] CRC_POLY   = 16'hA001;
    localparam logic [31:0] FAIL_VALUE = 32'hFFFFFBA9;

    localparam logic [7:0] QTY_HI     = 8'h00;
    localparam logic [7:0] QTY_LO     = 8'h02;
    localparam logic [7:0] BYTE_COUNT = 8'h04;

    // bytes ahead of the crc in each request frame
    localparam logic [3:0] WRITE_DATA_LEN = 4'd11;
    localparam logic [3:0] READ_DATA_LEN  = 4'd6;

    // reply lengths including the crc
    localparam logic [3:0] WRITE_REPLY_LEN = 4'd8;
    localparam logic [3:0] READ_REPLY_LEN  = 4'd9;

    // reply byte positions of interest
    localparam logic [3:0] POS_VALUE_FIRST = 4'd3;
    localparam logic [3:0] POS_VALUE_LAST  = 4'd6;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_NODE_ADDR  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_REPLY_ADDR = 1'b1;

    typedef enum logic [1:0] {
        KIND_WRITE,
        KIND_READ,
        KIND_REPLY
    } t_kind;

    typedef enum logic [1:0] {
        AW_NONE,
        AW_WRITE,
        AW_READ
    } t_await;

    typedef enum logic {
        BS_IDLE,
        BS_FRAME
    } t_bstate;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  func;
        logic [15:0] reg_addr;
        logic [31:0] value;
        logic [7:0]  rbyte;
    } t_entry;

    typedef struct packed {
        logic        is_transmit;
        logic [7:0]  send_byte;
        logic        last;
        logic        good;
        logic [31:0] read_result;
    } t_result;

    function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

// File: rtl/mbrtu_front.sv
// input side: takes stream items, drops unused action codes, merges the channel
// into the register address and pushes a command entry; uses mbrtu_pkg

module mbrtu_front
    import mbrtu_pkg::*;
(
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,
    input  logic [1:0]  s_axis_tuser,
    input  logic        i_full,
    output logic        o_push,
    output t_entry      o_entry
);

    logic [7:0]  w_func;
    logic [15:0] w_reg;
    logic [7:0]  w_chan;
    logic [31:0] w_value;
    logic [7:0]  w_rbyte;
    logic        w_known;

    assign w_func  = s_axis_tdata[7:0];
    assign w_reg   = s_axis_tdata[23:8];
    assign w_chan  = s_axis_tdata[31:24];
    assign w_value = s_axis_tdata[63:32];
    assign w_rbyte = s_axis_tdata[71:64];

    assign s_axis_tready = !i_full;

    always_comb begin
        w_known       = 1'b1;
        o_entry.kind  = KIND_REPLY;
        case (s_axis_tuser)
            ACT_WRITE: o_entry.kind = KIND_WRITE;
            ACT_READ:  o_entry.kind = KIND_READ;
            ACT_REPLY: o_entry.kind = KIND_REPLY;
            default:   w_known      = 1'b0;
        endcase
        o_entry.func     = w_func;
        o_entry.reg_addr = w_reg | {8'h00, w_chan};
        o_entry.value    = w_value;
        o_entry.rbyte    = w_rbyte;
    end

    assign o_push = s_axis_tvalid && !i_full && w_known;

endmodule

// File: rtl/mbrtu_queue.sv
// short command queue between the front and back parts
// uses mbrtu_pkg for the entry type

module mbrtu_queue
    import mbrtu_pkg::*;
#(
    parameter int DEPTH = 2
)(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_entry i_entry,
    output logic   o_full,
    input  logic   i_pop,
    output t_entry o_head,
    output logic   o_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_entry          r_mem [DEPTH];
    logic [PW-1:0]   r_wr;
    logic [PW-1:0]   r_rd;
    logic [CW-1:0]   r_count;
    logic [PW-1:0]   n_wr;
    logic [PW-1:0]   n_rd;
    logic [CW-1:0]   n_count;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd];

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (i_push) begin
            n_wr = (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (i_pop) begin
            n_rd = (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

endmodule

// File: rtl/mbrtu_back.sv
// back part: serializes request frames with crc, checks reply bytes and
// drives the registered result stage; holds the config registers; uses mbrtu_pkg

module mbrtu_back
    import mbrtu_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_empty,
    input  t_entry                i_head,
    output logic                  o_pop,
    output logic                  o_valid,
    output t_result               o_result,
    input  logic                  i_ready
);

    t_bstate     r_state,   n_state;
    t_kind       r_kind,    n_kind;
    logic [7:0]  r_func,    n_func;
    logic [15:0] r_reg,     n_reg;
    logic [31:0] r_value,   n_value;
    logic [3:0]  r_idx,     n_idx;
    logic [15:0] r_tx_crc,  n_tx_crc;
    t_await      r_await,   n_await;
    logic [3:0]  r_count,   n_count;
    logic [15:0] r_rx_crc,  n_rx_crc;
    logic        r_matched, n_matched;
    logic [31:0] r_gather,  n_gather;
    logic [7:0]  r_first,   n_first;
    logic [7:0]  r_node;
    logic [7:0]  r_reply_addr;
    logic        r_out_valid, n_out_valid;
    t_result     r_out,       n_out;

    logic        out_free;
    logic [3:0]  len_data;
    logic [7:0]  frame_byte;
    logic        frame_last;
    logic [3:0]  reply_total;
    logic        good;

    assign out_free    = !r_out_valid || i_ready;
    assign len_data    = (r_kind == KIND_WRITE) ? WRITE_DATA_LEN : READ_DATA_LEN;
    assign frame_last  = (r_idx == len_data + 4'd1);
    assign reply_total = (r_await == AW_WRITE) ? WRITE_REPLY_LEN : READ_REPLY_LEN;
    assign good        = r_matched && ({i_head.rbyte, r_first} == r_rx_crc);

    // request frame byte at the current position
    always_comb begin
        case (r_idx)
            4'd0:    frame_byte = r_node;
            4'd1:    frame_byte = r_func;
            4'd2:    frame_byte = r_reg[15:8];
            4'd3:    frame_byte = r_reg[7:0];
            4'd4:    frame_byte = QTY_HI;
            4'd5:    frame_byte = QTY_LO;
            4'd6:    frame_byte = BYTE_COUNT;
            4'd7:    frame_byte = r_value[31:24];
            4'd8:    frame_byte = r_value[23:16];
            4'd9:    frame_byte = r_value[15:8];
            4'd10:   frame_byte = r_value[7:0];
            default: frame_byte = 8'h00;
        endcase
        if (r_idx == len_data) begin
            frame_byte = r_tx_crc[7:0];
        end else if (frame_last) begin
            frame_byte = r_tx_crc[15:8];
        end
    end

    always_comb begin
        n_state     = r_state;
        n_kind      = r_kind;
        n_func      = r_func;
        n_reg       = r_reg;
        n_value     = r_value;
        n_idx       = r_idx;
        n_tx_crc    = r_tx_crc;
        n_await     = r_await;
        n_count     = r_count;
        n_rx_crc    = r_rx_crc;
        n_matched   = r_matched;
        n_gather    = r_gather;
        n_first     = r_first;
        n_out_valid = r_out_valid && !i_ready;
        n_out       = r_out;
        o_pop       = 1'b0;
        case (r_state)
            BS_IDLE: begin
                if (!i_empty && out_free) begin
                    o_pop = 1'b1;
                    case (i_head.kind)
                        KIND_WRITE, KIND_READ: begin
                            n_kind    = i_head.kind;
                            n_func    = i_head.func;
                            n_reg     = i_head.reg_addr;
                            n_value   = i_head.value;
                            n_idx     = '0;
                            n_tx_crc  = CRC_INIT;
                            n_await   = (i_head.kind == KIND_WRITE) ? AW_WRITE : AW_READ;
                            n_count   = '0;
                            n_rx_crc  = CRC_INIT;
                            n_matched = 1'b0;
                            n_gather  = '0;
                            n_first   = '0;
                            n_state   = BS_FRAME;
                        end
                        KIND_REPLY: begin
                            if (r_await != AW_NONE) begin
                                if (r_count == '0) begin
                                    n_matched = (i_head.rbyte == r_reply_addr);
                                end
                                if (r_count < reply_total - 4'd2) begin
                                    n_rx_crc = crc_feed(r_rx_crc, i_head.rbyte);
                                    if (r_await == AW_READ && r_count >= POS_VALUE_FIRST
                                        && r_count <= POS_VALUE_LAST) begin
                                        n_gather = {r_gather[23:0], i_head.rbyte};
                                    end
                                end else if (r_count == reply_total - 4'd2) begin
                                    n_first = i_head.rbyte;
                                end
                                n_count = r_count + 4'd1;
                                if (r_count + 4'd1 >= reply_total) begin
                                    n_out_valid       = 1'b1;
                                    n_out.is_transmit = 1'b0;
                                    n_out.send_byte   = 8'h00;
                                    n_out.last        = 1'b1;
                                    n_out.good        = good;
                                    if (r_await == AW_READ) begin
                                        n_out.read_result = good ? r_gather : FAIL_VALUE;
                                    end else begin
                                        n_out.read_result = '0;
                                    end
                                    n_await   = AW_NONE;
                                    n_count   = '0;
                                    n_rx_crc  = CRC_INIT;
                                    n_matched = 1'b0;
                                    n_gather  = '0;
                                    n_first   = '0;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
            end
            BS_FRAME: begin
                if (out_free) begin
                    n_out_valid       = 1'b1;
                    n_out.is_transmit = 1'b1;
                    n_out.send_byte   = frame_byte;
                    n_out.last        = frame_last;
                    n_out.good        = 1'b0;
                    n_out.read_result = '0;
                    if (r_idx < len_data) begin
                        n_tx_crc = crc_feed(r_tx_crc, frame_byte);
                    end
                    n_idx = r_idx + 4'd1;
                    if (frame_last) begin
                        n_state = BS_IDLE;
                    end
                end
            end
            default: n_state = BS_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= BS_IDLE;
            r_await      <= AW_NONE;
            r_count      <= '0;
            r_rx_crc     <= CRC_INIT;
            r_matched    <= 1'b0;
            r_gather     <= '0;
            r_first      <= '0;
            r_out_valid  <= 1'b0;
            r_node       <= 8'h01;
            r_reply_addr <= 8'h01;
        end else begin
            r_state     <= n_state;
            r_await     <= n_await;
            r_count     <= n_count;
            r_rx_crc    <= n_rx_crc;
            r_matched   <= n_matched;
            r_gather    <= n_gather;
            r_first     <= n_first;
            r_out_valid <= n_out_valid;
            if (i_cfg_we && i_cfg_index == CFG_NODE_ADDR) begin
                r_node <= i_cfg_data;
            end
            if (i_cfg_we && i_cfg_index == CFG_REPLY_ADDR) begin
                r_reply_addr <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind   <= n_kind;
        r_func   <= n_func;
        r_reg    <= n_reg;
        r_value  <= n_value;
        r_idx    <= n_idx;
        r_tx_crc <= n_tx_crc;
        r_out    <= n_out;
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

`ifndef ASSERT_OFF
    a_idx_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == BS_FRAME |-> r_idx <= len_data + 4'd1)
        else $error("frame index past end of frame");

    a_count_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_await == AW_NONE |-> r_count == '0)
        else $error("reply count nonzero with no reply pending");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_await != AW_NONE |-> r_count < reply_total)
        else $error("reply count reached reply length without verdict");

    a_frame_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == BS_FRAME && out_free && frame_last)
        |=> (r_state == BS_IDLE && r_out_valid && r_out.last && r_out.is_transmit))
        else $error("last frame byte not followed by idle");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> !i_empty)
        else $error("pop from empty queue");
`endif

endmodule

// File: rtl/modbus_rtu_request_framer_reply_checker.sv
// top level of the modbus rtu request framer and reply checker
// depends on mbrtu_pkg, mbrtu_front, mbrtu_queue and mbrtu_back
//
// s_axis carries commands: tuser is the action (write request, read request,
// reply byte), tdata the request fields and the received reply byte.
// m_axis carries results: tuser high for a frame byte, low for a verdict;
// tlast marks the final frame byte and every verdict.
// the config port sets the node address (index 0) and reply address (index 1).
// a command is accepted whenever the queue has room; frame bytes leave one per
// cycle while m_axis is ready, from a registered output stage fed through the
// queue and the back part's frame state. a write request frame is 13 bytes and
// a read request frame 8; the back part loads each request before its first
// byte and takes no next command until the frame's last byte is out. a verdict
// is registered when the last reply byte leaves the queue. when m_axis stalls,
// the output register holds and the queue fills, after which s_axis_tready drops.
// reset empties the queue, drops any pending reply and sets both addresses to 1.

module modbus_rtu_request_framer_reply_checker
    import mbrtu_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // function_code, register_address, channel, write_value, reply_byte
    input  logic [71:0]           s_axis_tdata,
    input  logic [1:0]            s_axis_tuser,   // action
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [47:0]           m_axis_tdata,   // send_byte, reply_good, read_result, zero pad
    output logic [0:0]            m_axis_tuser,   // is_transmit
    output logic                  m_axis_tlast
);

    logic    w_push;
    t_entry  w_entry;
    logic    w_full;
    logic    w_pop;
    t_entry  w_head;
    logic    w_empty;
    t_result w_result;

    mbrtu_front u_front (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .i_full        (w_full),
        .o_push        (w_push),
        .o_entry       (w_entry)
    );

    mbrtu_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_entry),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_empty (w_empty)
    );

    mbrtu_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_empty     (w_empty),
        .i_head      (w_head),
        .o_pop       (w_pop),
        .o_valid     (m_axis_tvalid),
        .o_result    (w_result),
        .i_ready     (m_axis_tready)
    );

    assign m_axis_tdata = {7'd0, w_result.read_result, w_result.good, w_result.send_byte};
    assign m_axis_tuser = w_result.is_transmit;
    assign m_axis_tlast = w_result.last;

endmodule
